/* hw/rtl/lrupr_pkg.sv */
// Shared types and constants for the LRU page replacement core.
`timescale 1ns / 1ps
package lrupr_pkg;

	localparam int PAGE_W    = 6;
	localparam int PAGE_SPAN = 1 << PAGE_W;
	localparam int FAULT_W   = 16;
	localparam int CNT_W     = 5;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [CNT_W-1:0]   FRAME_COUNT_RST  = 5'd4;
	localparam logic [FAULT_W-1:0] FAULT_MAX        = 16'hFFFF;
	localparam logic [ADDR_W-1:0]  ADDR_FRAME_COUNT = 3'd0;

	// Data passed from one stack cell to the next (toward the least recent end)
	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic              valid;
		logic              seen;   // a match exists at this position or a more recent one
	} link_t;

	// Per-transfer control broadcast to every cell
	typedef struct packed {
		logic load;
		logic hit;
		logic evict;
		logic clear;
	} ctrl_t;

endpackage

/* hw/rtl/lrupr_cell.sv */
// One position of the recency stack: holds a page, compares, and shifts from its neighbor.
`timescale 1ns / 1ps
module lrupr_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lrupr_pkg::PAGE_W-1:0]  ref_page,
	input  lrupr_pkg::ctrl_t              ctrl,
	input  lrupr_pkg::link_t              link_in,
	input  logic                          next_valid,
	output lrupr_pkg::link_t              link_out,
	output logic                          tail
);
	import lrupr_pkg::*;

	logic [PAGE_W-1:0] page_q;
	logic              valid_q;
	logic              match;
	logic              shift;

	assign match = valid_q && (page_q == ref_page);

	assign link_out.page  = page_q;
	assign link_out.valid = valid_q;
	assign link_out.seen  = link_in.seen | match;

	// last occupied position: its page is the eviction candidate
	assign tail = valid_q && !next_valid;

	always_comb begin
		if (ctrl.hit) begin
			shift = !link_in.seen;
		end else if (ctrl.evict) begin
			shift = valid_q;
		end else begin
			shift = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.load) begin
			if (ctrl.clear) begin
				valid_q <= 1'b0;
			end else if (shift) begin
				valid_q <= link_in.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load && shift) begin
			page_q <= link_in.page;
		end
	end

endmodule

/* hw/rtl/lru_page_replacement_core.sv */
// LRU page replacement: recency stack built from a chain of compare-and-shift cells.
// Result is registered and valid in the cycle after the input transfer.
// Throughput: one reference per cycle while in_stall is low; the whole cell chain compares and shifts in one step.
// Input stall rises only while a finished result waits and the output is stalled.
// Reset empties the stack, clears the fault count and sets frame_count to 4.
`timescale 1ns / 1ps
module lru_page_replacement_core #(
	parameter int FRAMES = 16,
	parameter int PAGES  = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB-style configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lrupr_pkg::ADDR_W-1:0]   paddr,
	input  logic [lrupr_pkg::DATA_W-1:0]   pwdata,
	output logic [lrupr_pkg::DATA_W-1:0]   prdata,
	output logic                           pready,
	// reference input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lrupr_pkg::PAGE_W-1:0]   page_ref,
	input  logic                           last_ref,
	// result output
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic                           evict_valid,
	output logic [lrupr_pkg::PAGE_W-1:0]   evict_page,
	output logic [lrupr_pkg::FAULT_W-1:0]  fault_total,
	output logic [lrupr_pkg::CNT_W-1:0]    resident_count
);
	import lrupr_pkg::*;

	localparam int OCC_W = $clog2(FRAMES + 1);

	// configuration
	logic [CNT_W-1:0] frame_count_q;
	logic             cfg_wr;
	logic [OCC_W-1:0] frame_lim;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_FRAME_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
		end else if (cfg_wr) begin
			frame_count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		if (paddr == ADDR_FRAME_COUNT) begin
			prdata = DATA_W'(frame_count_q);
		end else begin
			prdata = '0;
		end
	end

	always_comb begin
		if (frame_count_q == '0) begin
			frame_lim = OCC_W'(1);
		end else if (32'(frame_count_q) > FRAMES) begin
			frame_lim = OCC_W'(FRAMES);
		end else begin
			frame_lim = OCC_W'(frame_count_q);
		end
	end

	// page number reduction table
	logic [PAGE_W-1:0] page_tbl [PAGE_SPAN];
	logic [PAGE_W-1:0] ref_page;

	for (genvar v = 0; v < PAGE_SPAN; v++) begin : g_page_tbl
		assign page_tbl[v] = PAGE_W'(v % PAGES);
	end

	assign ref_page = page_tbl[page_ref];

	// handshake
	logic accept;

	assign in_stall = out_valid && out_stall;
	assign accept   = in_valid && !in_stall;

	// cell chain
	link_t            links [FRAMES+1];
	logic [FRAMES:0]  valids;
	logic [FRAMES-1:0] tails;
	ctrl_t            ctrl;
	logic             is_hit;
	logic             is_evict;
	logic [OCC_W-1:0] occ_q;
	logic [PAGE_W-1:0] tail_page;

	assign links[0].page  = ref_page;
	assign links[0].valid = 1'b1;
	assign links[0].seen  = 1'b0;

	assign valids[FRAMES] = 1'b0;

	for (genvar k = 0; k < FRAMES; k++) begin : g_cell
		assign valids[k] = links[k+1].valid;

		lrupr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ref_page   (ref_page),
			.ctrl       (ctrl),
			.link_in    (links[k]),
			.next_valid (valids[k+1]),
			.link_out   (links[k+1]),
			.tail       (tails[k])
		);
	end

	assign is_hit   = links[FRAMES].seen;
	assign is_evict = !is_hit && (occ_q >= frame_lim);

	assign ctrl.load  = accept;
	assign ctrl.hit   = is_hit;
	assign ctrl.evict = is_evict;
	assign ctrl.clear = last_ref;

	always_comb begin
		tail_page = '0;
		for (int k = 0; k < FRAMES; k++) begin
			tail_page = tail_page | (tails[k] ? links[k+1].page : '0);
		end
	end

	// occupancy and fault count
	logic [FAULT_W-1:0] fault_q;
	logic [FAULT_W-1:0] fault_nxt;
	logic [OCC_W-1:0]   occ_nxt;

	always_comb begin
		fault_nxt = fault_q;
		if (!is_hit && fault_q != FAULT_MAX) begin
			fault_nxt = fault_q + 1'b1;
		end
		occ_nxt = occ_q;
		if (!is_hit && !is_evict) begin
			occ_nxt = occ_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= '0;
			occ_q   <= '0;
		end else if (accept) begin
			fault_q <= last_ref ? '0 : fault_nxt;
			occ_q   <= last_ref ? '0 : occ_nxt;
		end
	end

	// output register
	logic               out_valid_q;
	logic               hit_q;
	logic               evict_valid_q;
	logic [PAGE_W-1:0]  evict_page_q;
	logic [FAULT_W-1:0] fault_total_q;
	logic [CNT_W-1:0]   resident_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q            <= is_hit;
			evict_valid_q    <= is_evict;
			evict_page_q     <= is_evict ? tail_page : '0;
			fault_total_q    <= fault_nxt;
			resident_count_q <= CNT_W'(occ_nxt);
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign evict_valid    = evict_valid_q;
	assign evict_page     = evict_page_q;
	assign fault_total    = fault_total_q;
	assign resident_count = resident_count_q;

endmodule

/* hw/rtl/lrupr_checker.sv */
// Port-level checks for the LRU page replacement core, bound to the top level.
`timescale 1ns / 1ps
module lrupr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           hit,
	input logic                           evict_valid,
	input logic [lrupr_pkg::PAGE_W-1:0]   evict_page,
	input logic [lrupr_pkg::FAULT_W-1:0]  fault_total,
	input logic [lrupr_pkg::CNT_W-1:0]    resident_count
);
	import lrupr_pkg::*;

	// an eviction only happens on a miss
	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evict_valid |-> !hit)
		else $error("eviction reported on a hit");

	a_evict_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evict_valid |-> evict_page == '0)
		else $error("evict_page nonzero without eviction");

	// a miss always counts at least one fault in the sequence
	a_miss_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> fault_total != '0)
		else $error("miss with zero fault total");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(evict_page)
			&& $stable(fault_total) && $stable(resident_count))
		else $error("stalled result changed");

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (.*);

/* sim/tb_top.sv */
// Self-checking testbench for lru_page_replacement_core: directed table, then random sequences.
`timescale 1ns / 1ps
module tb_top;
	import lrupr_pkg::*;

	localparam int NFRAMES   = 16;
	localparam int HOLD_LEN  = 200;
	localparam int WDOG_MAX  = 2000;
	localparam int PHASES    = 11;
	localparam int PHASE_LEN = 90;

	typedef struct packed {
		logic               hit;
		logic               evict_valid;
		logic [PAGE_W-1:0]  evict_page;
		logic [FAULT_W-1:0] fault_total;
		logic [CNT_W-1:0]   resident_count;
	} lookup_res_t;

	typedef struct packed {
		logic              wr_frames;
		logic [CNT_W-1:0]  frames;
		logic [PAGE_W-1:0] page;
		logic              last;
		logic              typed;
		lookup_res_t       res;
	} ref_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata, prdata;
	logic               pready;
	logic               in_valid, in_stall;
	logic [PAGE_W-1:0]  page_ref;
	logic               last_ref;
	logic               out_valid, out_stall;
	logic               hit, evict_valid;
	logic [PAGE_W-1:0]  evict_page;
	logic [FAULT_W-1:0] fault_total;
	logic [CNT_W-1:0]   resident_count;

	lru_page_replacement_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .page_ref(page_ref), .last_ref(last_ref),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit), .evict_valid(evict_valid),
		.evict_page(evict_page), .fault_total(fault_total), .resident_count(resident_count)
	);

	always #1 clk = ~clk;

	// shadow of the recency stack, position 0 most recent
	logic [PAGE_W-1:0]  stk_page [NFRAMES];
	logic               stk_valid [NFRAMES];
	logic [FAULT_W-1:0] faults;
	logic [CNT_W-1:0]   frames_reg = FRAME_COUNT_RST;

	lookup_res_t lookups_pending [$];
	int          mismatches = 0;
	int          stall_pct  = 0;
	bit          bursty     = 1'b0;
	int          burst_left = 0;
	bit          hold_req   = 1'b0;
	int          idle_cycles = 0;

	function automatic void clear_stack();
		for (int k = 0; k < NFRAMES; k++) begin
			stk_page[k]  = '0;
			stk_valid[k] = 1'b0;
		end
		faults = '0;
	endfunction

	function automatic void push_front(input int top, input logic [PAGE_W-1:0] pg);
		for (int k = top; k > 0; k--) begin
			stk_page[k]  = stk_page[k-1];
			stk_valid[k] = stk_valid[k-1];
		end
		stk_page[0]  = pg;
		stk_valid[0] = 1'b1;
	endfunction

	function automatic lookup_res_t lru_lookup(input logic [PAGE_W-1:0] pg, input logic last);
		int          occ;
		int          lim;
		int          pos;
		lookup_res_t r;
		occ = 0;
		while (occ < NFRAMES && stk_valid[occ])
			occ++;
		lim = frames_reg;
		if (lim == 0)
			lim = 1;
		if (lim > NFRAMES)
			lim = NFRAMES;
		pos = NFRAMES;
		for (int k = 0; k < occ; k++)
			if (pos == NFRAMES && stk_page[k] == pg)
				pos = k;
		r = '0;
		if (pos < occ) begin
			r.hit = 1'b1;
			push_front(pos, pg);
		end else begin
			if (faults != FAULT_MAX)
				faults++;
			if (occ >= lim) begin
				// full (or over the lowered limit): drop only the least recent page
				r.evict_valid = 1'b1;
				r.evict_page  = stk_page[occ-1];
				push_front(occ - 1, pg);
			end else begin
				push_front(occ, pg);
				occ++;
			end
		end
		r.fault_total    = faults;
		r.resident_count = CNT_W'(occ);
		if (last)
			clear_stack();
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned exp_v,
			input int unsigned got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
	endtask

	task automatic send_ref(input logic [PAGE_W-1:0] pg, input logic last,
			input logic typed, input lookup_res_t typed_res);
		lookup_res_t r;
		int          gap;
		if (bursty && burst_left == 0) begin
			gap        = $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		page_ref <= pg;
		last_ref <= last;
		do @(posedge clk); while (in_stall);
		r = lru_lookup(pg, last);
		lookups_pending.push_back(typed ? typed_res : r);
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic drain_lookups();
		in_valid <= 1'b0;
		while (lookups_pending.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [CNT_W-1:0] v);
		logic [DATA_W-1:0] wdata;
		wdata = $urandom;
		wdata[CNT_W-1:0] = v;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_FRAME_COUNT;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (!wr && prdata[CNT_W-1:0] !== frames_reg)
			flag_mismatch("frame_count readback", frames_reg, prdata[CNT_W-1:0]);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frames(input logic [CNT_W-1:0] v);
		apb_access(1'b1, v);
		frames_reg = v;
		apb_access(1'b0, '0);
	endtask

	always @(posedge clk) begin
		lookup_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (lookups_pending.size() == 0) begin
				flag_mismatch("unexpected result", 0, 1);
			end else begin
				want = lookups_pending.pop_front();
				if (hit !== want.hit)
					flag_mismatch("hit", want.hit, hit);
				if (evict_valid !== want.evict_valid)
					flag_mismatch("evict_valid", want.evict_valid, evict_valid);
				if (evict_page !== want.evict_page)
					flag_mismatch("evict_page", want.evict_page, evict_page);
				if (fault_total !== want.fault_total)
					flag_mismatch("fault_total", want.fault_total, fault_total);
				if (resident_count !== want.resident_count)
					flag_mismatch("resident_count", want.resident_count, resident_count);
			end
		end
	end

	// receiver: runs of stall/no-stall, plus one long hold-off on request
	initial begin
		int run;
		int hold_left;
		run       = 0;
		hold_left = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (run > 0) begin
				run--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
				run = $urandom_range(0, 5);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_MAX) begin
				$display("lru_page_replacement_core regression: fail");
				$finish;
			end
		end
	end

	ref_row_t directed [19] = '{
		'{1'b0, 5'd0,  6'd0,  1'b0, 1'b1, '{1'b0, 1'b0, 6'd0,  16'd1, 5'd1}},
		'{1'b0, 5'd0,  6'd63, 1'b0, 1'b1, '{1'b0, 1'b0, 6'd0,  16'd2, 5'd2}},
		'{1'b0, 5'd0,  6'd0,  1'b0, 1'b1, '{1'b1, 1'b0, 6'd0,  16'd2, 5'd2}},
		'{1'b0, 5'd0,  6'd5,  1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  6'd9,  1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  6'd12, 1'b0, 1'b1, '{1'b0, 1'b1, 6'd63, 16'd5, 5'd4}},
		'{1'b0, 5'd0,  6'd0,  1'b1, 1'b1, '{1'b1, 1'b0, 6'd0,  16'd5, 5'd4}},
		'{1'b0, 5'd0,  6'd0,  1'b0, 1'b1, '{1'b0, 1'b0, 6'd0,  16'd1, 5'd1}},
		// zero frames behaves as one
		'{1'b1, 5'd0,  6'd7,  1'b0, 1'b1, '{1'b0, 1'b1, 6'd0,  16'd2, 5'd1}},
		'{1'b0, 5'd0,  6'd7,  1'b0, 1'b1, '{1'b1, 1'b0, 6'd0,  16'd2, 5'd1}},
		'{1'b0, 5'd0,  6'd42, 1'b1, 1'b1, '{1'b0, 1'b1, 6'd7,  16'd3, 5'd1}},
		'{1'b1, 5'd16, 6'd1,  1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  6'd2,  1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  6'd3,  1'b0, 1'b0, '0},
		// limit lowered below occupancy: one eviction, occupancy holds
		'{1'b1, 5'd2,  6'd4,  1'b0, 1'b1, '{1'b0, 1'b1, 6'd1,  16'd4, 5'd3}},
		'{1'b0, 5'd0,  6'd2,  1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  6'd3,  1'b1, 1'b0, '0},
		'{1'b1, 5'd31, 6'd10, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  6'd20, 1'b1, 1'b0, '0}
	};

	initial begin
		ref_row_t          row;
		logic [CNT_W-1:0]  phase_frames [PHASES];
		logic [PAGE_W-1:0] pg;
		logic              lst;
		int                sent, seq_len, span, base, lim;
		bit                noise;
		phase_frames = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd8, 5'd2, 5'd17, 5'd12, 5'd3, 5'd5};
		phase_frames[PHASES-1] = CNT_W'($urandom_range(31));
		clear_stack();
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		in_valid = 1'b0;
		page_ref = '0;
		last_ref = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_access(1'b0, '0);
		bursty    = 1'b1;
		stall_pct = 30;
		for (int i = 0; i < $size(directed); i++) begin
			row = directed[i];
			if (row.wr_frames) begin
				drain_lookups();
				set_frames(row.frames);
			end
			send_ref(row.page, row.last, row.typed, row.res);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_lookups();
			set_frames(phase_frames[ph]);
			bursty    = (ph % 3 != 0);
			stall_pct = (ph == 0) ? 0 : 10 * ((ph * 3) % 9);
			if (ph == 3)
				hold_req = 1'b1;
			lim = (frames_reg == 0) ? 1 : (frames_reg > NFRAMES) ? NFRAMES : frames_reg;
			sent = 0;
			while (sent < PHASE_LEN) begin
				seq_len = $urandom_range(1, 40);
				noise   = ($urandom_range(9) == 0);
				span    = lim + $urandom_range(0, 3);
				base    = $urandom_range(63);
				for (int k = 0; k < seq_len; k++) begin
					pg  = noise ? PAGE_W'($urandom_range(63))
					            : PAGE_W'(base + $urandom_range(span - 1));
					// some sequences stay open so the next setting starts on a filled stack
					lst = (k == seq_len - 1) && ($urandom_range(3) != 0);
					send_ref(pg, lst, 1'b0, '0);
				end
				sent += seq_len;
				if (ph == 5 && sent < PHASE_LEN / 2)
					drain_lookups();
			end
		end

		in_valid <= 1'b0;
		while (lookups_pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0 && lookups_pending.size() == 0) begin
			$display("lru_page_replacement_core regression: pass");
		end else begin
			$display("lru_page_replacement_core regression: fail");
		end
		$finish;
	end

endmodule
